>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/rmf_pkg.sv
// Shared constants and types of the RMS/EDF/(m,k)-firm task picker.
package rmf_pkg;

    localparam int TASK_COUNT = 3;
    localparam int WINDOW_MAX = 8;

    localparam int TASK_W  = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
    localparam int POS_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int DL_W    = 32;
    localparam int PER_W   = 16;
    localparam int FIRM_W  = 8;
    localparam int FIELD_W = 4;
    localparam int CNT_W   = 4;
    localparam int MODE_W  = 2;
    localparam int DATA_W  = 32;

    localparam int REG_COUNT = 2 * TASK_COUNT + 1;
    localparam int REG_IDX_W = $clog2(REG_COUNT);
    localparam int ADDR_W    = REG_IDX_W + 2;

    localparam int REG_MODE        = 0;
    localparam int REG_PERIOD_BASE = 1;
    localparam int REG_FIRM_BASE   = 1 + TASK_COUNT;

    localparam logic [MODE_W-1:0] MODE_RMS  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EDF  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIRM = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef logic [MODE_W-1:0]                   t_mode;
    typedef logic [TASK_COUNT-1:0][PER_W-1:0]    t_period_arr;
    typedef logic [TASK_COUNT-1:0][FIRM_W-1:0]   t_firm_arr;
    typedef logic [TASK_COUNT-1:0][DL_W-1:0]     t_dl_arr;

    typedef struct packed {
        t_mode       mode;
        t_period_arr period;
        t_firm_arr   firm;
    } t_cfg;

    // Window update command for one task: rec records an outcome, succ is its value.
    typedef struct packed {
        logic rec;
        logic succ;
    } t_win_upd;

endpackage

>>> rtl/rmf_if.sv
// Valid/ready channel interfaces for decision requests and results.
interface rmf_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  ready_mask;
    logic [31:0] deadline_task0;
    logic [31:0] deadline_task1;
    logic [31:0] deadline_task2;

    modport source (output valid, ready_mask, deadline_task0, deadline_task1,
                    deadline_task2, input ready);
    modport sink   (input valid, ready_mask, deadline_task0, deadline_task1,
                    deadline_task2, output ready);
endinterface

interface rmf_out_if;
    logic       valid;
    logic       ready;
    logic       pick_valid;
    logic [1:0] picked_task;
    logic [2:0] dropped_mask;

    modport source (output valid, pick_valid, picked_task, dropped_mask, input ready);
    modport sink   (input valid, pick_valid, picked_task, dropped_mask, output ready);
endinterface

>>> rtl/rms_edf_mk_firm_task_picker.sv
// Top level of the RMS/EDF/(m,k)-firm task picker.
// One decision request in, one result out. A request is captured in an input
// register, judged combinationally against the configured policy and the per-task
// (m,k) windows, and moves into the result register once that is empty or draining.
// The window state is updated in the same cycle the decision is made, so a new
// request can be accepted every cycle while results drain: sustained rate is one item
// per clock, set by the single compute stage between the input and result registers.
// The input side keeps accepting while a result waits, until both registers are
// full. Configuration goes through the APB port; write it only while idle.
module rms_edf_mk_firm_task_picker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    rmf_in_if.sink                     i_in,
    rmf_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rmf_pkg::ADDR_W-1:0] paddr,
    input  logic [rmf_pkg::DATA_W-1:0] pwdata,
    output logic [rmf_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    rmf_pkg::t_cfg                  cfg;
    logic                           in_acc;
    logic                           adv;
    logic                           firm_mode;
    logic [rmf_pkg::TASK_COUNT-1:0] may_drop;
    logic [rmf_pkg::TASK_COUNT-1:0] drop;
    logic [rmf_pkg::TASK_COUNT-1:0] elig;
    logic                           found;
    logic [rmf_pkg::TASK_W-1:0]     best;
    rmf_pkg::t_win_upd              upd [rmf_pkg::TASK_COUNT];

    logic                           r_in_valid;
    logic [rmf_pkg::TASK_COUNT-1:0] r_in_mask;
    rmf_pkg::t_dl_arr               r_in_dl;

    logic                           r_out_valid;
    logic                           r_out_pick;
    logic [rmf_pkg::TASK_W-1:0]     r_out_task;
    logic [rmf_pkg::TASK_COUNT-1:0] r_out_drop;

    rmf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // result register advances when it is empty or being drained
    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_mask  <= i_in.ready_mask;
            r_in_dl[0] <= i_in.deadline_task0;
            r_in_dl[1] <= i_in.deadline_task1;
            r_in_dl[2] <= i_in.deadline_task2;
        end
    end

    assign firm_mode = (cfg.mode == rmf_pkg::MODE_FIRM);
    assign drop      = (firm_mode ? may_drop : '0) & r_in_mask;
    assign elig      = r_in_mask & ~drop;

    generate
        for (genvar t = 0; t < rmf_pkg::TASK_COUNT; t++) begin : g_win
            assign upd[t].rec  = adv && (drop[t] ||
                                 (firm_mode && found && (best == rmf_pkg::TASK_W'(t))));
            assign upd[t].succ = !drop[t];

            rmf_window u_window (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_firm     (cfg.firm[t]),
                .i_upd      (upd[t]),
                .o_may_drop (may_drop[t])
            );
        end
    endgenerate

    rmf_pick u_pick (
        .i_mode     (cfg.mode),
        .i_elig     (elig),
        .i_period   (cfg.period),
        .i_deadline (r_in_dl),
        .o_found    (found),
        .o_best     (best)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_pick <= found;
            r_out_task <= found ? best : '0;
            r_out_drop <= drop;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.pick_valid   = r_out_pick;
    assign o_out.picked_task  = r_out_task;
    assign o_out.dropped_mask = r_out_drop;

endmodule

>>> rtl/rmf_regs.sv
// APB configuration registers: policy mode, task periods, (m,k) windows.
module rmf_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rmf_pkg::ADDR_W-1:0] paddr,
    input  logic [rmf_pkg::DATA_W-1:0] pwdata,
    output logic [rmf_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output rmf_pkg::t_cfg              o_cfg
);

    logic [rmf_pkg::REG_IDX_W-1:0] idx;
    logic                          wr;
    rmf_pkg::t_cfg                 r_cfg;
    rmf_pkg::t_cfg                 n_cfg;

    assign idx    = paddr[rmf_pkg::ADDR_W-1:2];
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr) begin
            if (idx == rmf_pkg::REG_IDX_W'(rmf_pkg::REG_MODE)) begin
                n_cfg.mode = pwdata[rmf_pkg::MODE_W-1:0];
            end
            for (int i = 0; i < rmf_pkg::TASK_COUNT; i++) begin
                if (idx == rmf_pkg::REG_IDX_W'(rmf_pkg::REG_PERIOD_BASE + i)) begin
                    n_cfg.period[i] = pwdata[rmf_pkg::PER_W-1:0];
                end
                if (idx == rmf_pkg::REG_IDX_W'(rmf_pkg::REG_FIRM_BASE + i)) begin
                    n_cfg.firm[i] = pwdata[rmf_pkg::FIRM_W-1:0];
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (idx == rmf_pkg::REG_IDX_W'(rmf_pkg::REG_MODE)) begin
            prdata = rmf_pkg::DATA_W'(r_cfg.mode);
        end
        for (int i = 0; i < rmf_pkg::TASK_COUNT; i++) begin
            if (idx == rmf_pkg::REG_IDX_W'(rmf_pkg::REG_PERIOD_BASE + i)) begin
                prdata = rmf_pkg::DATA_W'(r_cfg.period[i]);
            end
            if (idx == rmf_pkg::REG_IDX_W'(rmf_pkg::REG_FIRM_BASE + i)) begin
                prdata = rmf_pkg::DATA_W'(r_cfg.firm[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> rtl/rmf_window.sv
// Per-task (m,k)-firm outcome window: history bits, slot pointer, success count.
module rmf_window (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [rmf_pkg::FIRM_W-1:0] i_firm,
    input  rmf_pkg::t_win_upd          i_upd,
    output logic                       o_may_drop
);

    logic [rmf_pkg::FIELD_W-1:0]    k_raw;
    logic [rmf_pkg::FIELD_W-1:0]    k;
    logic [rmf_pkg::FIELD_W-1:0]    m;
    logic [rmf_pkg::FIELD_W-1:0]    pos_inc;
    logic [rmf_pkg::CNT_W-1:0]      cnt_a;
    logic [rmf_pkg::WINDOW_MAX-1:0] r_hist, n_hist;
    logic [rmf_pkg::POS_W-1:0]      r_pos, n_pos;
    logic [rmf_pkg::CNT_W-1:0]      r_cnt, n_cnt;

    assign k_raw = i_firm[rmf_pkg::FIRM_W-1:rmf_pkg::FIELD_W];
    assign m     = i_firm[rmf_pkg::FIELD_W-1:0];
    assign k     = (k_raw > rmf_pkg::FIELD_W'(rmf_pkg::WINDOW_MAX))
                   ? rmf_pkg::FIELD_W'(rmf_pkg::WINDOW_MAX) : k_raw;

    assign o_may_drop = (k != '0) && (m != '0) && (r_cnt >= m);

    assign pos_inc = rmf_pkg::FIELD_W'(r_pos) + rmf_pkg::FIELD_W'(1);

    always_comb begin
        n_hist = r_hist;
        n_pos  = r_pos;
        n_cnt  = r_cnt;
        // the slot being overwritten gives back its success first
        cnt_a  = (r_hist[r_pos] && (r_cnt != '0)) ? r_cnt - 1'b1 : r_cnt;
        if (i_upd.rec && (k != '0)) begin
            n_hist[r_pos] = i_upd.succ;
            n_cnt         = (i_upd.succ && (cnt_a != rmf_pkg::CNT_MAX)) ? cnt_a + 1'b1
                                                                        : cnt_a;
            // a shrunken window wraps the pointer back to slot zero
            n_pos         = (pos_inc >= k) ? '0 : pos_inc[rmf_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
            r_pos  <= '0;
            r_cnt  <= '0;
        end else begin
            r_hist <= n_hist;
            r_pos  <= n_pos;
            r_cnt  <= n_cnt;
        end
    end

endmodule

>>> rtl/rmf_pick.sv
// Priority pick: smallest key among eligible tasks, ties to the lowest index.
module rmf_pick (
    input  rmf_pkg::t_mode                 i_mode,
    input  logic [rmf_pkg::TASK_COUNT-1:0] i_elig,
    input  rmf_pkg::t_period_arr           i_period,
    input  rmf_pkg::t_dl_arr               i_deadline,
    output logic                           o_found,
    output logic [rmf_pkg::TASK_W-1:0]     o_best
);

    rmf_pkg::t_dl_arr               key;
    logic [rmf_pkg::TASK_COUNT-1:0] win;

    always_comb begin
        for (int i = 0; i < rmf_pkg::TASK_COUNT; i++) begin
            key[i] = (i_mode == rmf_pkg::MODE_RMS) ? rmf_pkg::DL_W'(i_period[i])
                                                   : i_deadline[i];
        end
    end

    // a task wins when it beats every lower index strictly and no higher one beats it
    always_comb begin
        for (int i = 0; i < rmf_pkg::TASK_COUNT; i++) begin
            win[i] = i_elig[i];
            for (int j = 0; j < rmf_pkg::TASK_COUNT; j++) begin
                if (j < i) begin
                    win[i] = win[i] && (!i_elig[j] || (key[i] < key[j]));
                end else if (j > i) begin
                    win[i] = win[i] && (!i_elig[j] || (key[i] <= key[j]));
                end
            end
        end
    end

    always_comb begin
        o_best = '0;
        for (int i = 0; i < rmf_pkg::TASK_COUNT; i++) begin
            if (win[i]) begin
                o_best = o_best | rmf_pkg::TASK_W'(i);
            end
        end
    end

    assign o_found = |i_elig;

endmodule

>>> rtl/rmf_checker.sv
// Port-level checks of the task picker, bound to the top level.
`include "assert_macros.svh"

module rmf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_pick_valid,
    input logic [1:0] i_picked_task,
    input logic [2:0] i_dropped_mask
);

    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

    `ASSERT_CLK(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable({i_pick_valid, i_picked_task, i_dropped_mask}), "stalled result changed")

    `ASSERT_CLK(a_idle_zero, i_clk, i_rst_n, i_out_valid && !i_pick_valid |-> i_picked_task == 2'd0, "no pick but nonzero index")

    `ASSERT_CLK(a_pick_not_dropped, i_clk, i_rst_n, i_out_valid && i_pick_valid |-> ((i_dropped_mask >> i_picked_task) & 3'd1) == 3'd0, "picked task was also dropped")

endmodule

bind rms_edf_mk_firm_task_picker rmf_checker u_rmf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_pick_valid   (o_out.pick_valid),
    .i_picked_task  (o_out.picked_task),
    .i_dropped_mask (o_out.dropped_mask)
);

>>> dv/rms_edf_mk_firm_task_picker_test.sv
// Self-checking testbench for the RMS/EDF/(m,k)-firm task picker.
`timescale 1ns / 100ps

module rms_edf_mk_firm_task_picker_test;
    import rmf_pkg::*;

    localparam t_mode MODE_SPARE      = 2'd3;   // undefined code, behaves as EDF
    localparam int    PHASES          = 12;
    localparam int    ITEMS_PER_PHASE = 96;
    localparam int    STALL_LIMIT     = 1000;
    localparam int    IDLE_PCT        = 17;

    typedef struct packed {
        logic       pick_valid;
        logic [1:0] picked_task;
        logic [2:0] dropped_mask;
    } pick_t;

    typedef struct {
        int         cfg_sel;
        logic [2:0] mask;
        t_dl_arr    dl;
        bit         typed;
        pick_t      want;
    } dir_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    rmf_in_if  req_if ();
    rmf_out_if res_if ();

    rms_edf_mk_firm_task_picker DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state: configuration copy and per-task (m,k) windows
    t_cfg                  sched_cfg = '0;
    logic [WINDOW_MAX-1:0] win_hist [TASK_COUNT] = '{default: '0};
    logic [POS_W-1:0]      win_pos  [TASK_COUNT] = '{default: '0};
    logic [CNT_W-1:0]      win_succ [TASK_COUNT] = '{default: '0};

    pick_t    picks_due [$];
    dir_row_t dir_rows [$];
    t_cfg     dir_cfgs [6];
    pick_t    want;
    int       mismatch_count = 0;
    int       stall_cycles = 0;
    bit       no_idle = 1'b0;

    function automatic int window_len(int t);
        int k;
        k = int'(sched_cfg.firm[t][FIRM_W-1:FIELD_W]);
        return (k > WINDOW_MAX) ? WINDOW_MAX : k;
    endfunction

    function automatic void log_outcome(int t, logic success);
        int k;
        int pos;
        k = window_len(t);
        if (k == 0) return;
        pos = int'(win_pos[t]);
        // overwritten slot gives back its success first
        if (win_hist[t][pos] && win_succ[t] != '0) win_succ[t]--;
        if (success) begin
            win_hist[t][pos] = 1'b1;
            if (win_succ[t] != CNT_MAX) win_succ[t]++;
        end else begin
            win_hist[t][pos] = 1'b0;
        end
        // wraps also when k shrank below the current position
        win_pos[t] = POS_W'((pos + 1 >= k) ? 0 : pos + 1);
    endfunction

    function automatic pick_t predict_pick(logic [2:0] mask, t_dl_arr dl);
        logic [2:0]  live;
        logic [2:0]  dropped;
        logic        found;
        int          best;
        int          need;
        logic [31:0] key;
        logic [31:0] best_key;
        pick_t       p;
        live = mask;
        dropped = '0;
        found = 1'b0;
        best = 0;
        best_key = '0;
        if (sched_cfg.mode == MODE_FIRM) begin
            for (int t = 0; t < TASK_COUNT; t++) begin
                need = int'(sched_cfg.firm[t][FIELD_W-1:0]);
                if (live[t] && window_len(t) != 0 && need != 0 && int'(win_succ[t]) >= need) begin
                    log_outcome(t, 1'b0);
                    dropped[t] = 1'b1;
                end
            end
            live &= ~dropped;
        end
        for (int t = 0; t < TASK_COUNT; t++) begin
            if (!live[t]) continue;
            key = (sched_cfg.mode == MODE_RMS) ? 32'(sched_cfg.period[t]) : dl[t];
            if (!found || key < best_key) begin
                found = 1'b1;
                best = t;
                best_key = key;
            end
        end
        if (found && sched_cfg.mode == MODE_FIRM) log_outcome(best, 1'b1);
        p.pick_valid = found;
        p.picked_task = found ? 2'(best) : 2'd0;
        p.dropped_mask = dropped;
        return p;
    endfunction

    function automatic t_cfg make_cfg(t_mode mode, logic [15:0] p0, logic [15:0] p1,
                                      logic [15:0] p2, logic [7:0] f0, logic [7:0] f1,
                                      logic [7:0] f2);
        t_cfg c;
        c.mode = mode;
        c.period[0] = p0;
        c.period[1] = p1;
        c.period[2] = p2;
        c.firm[0] = f0;
        c.firm[1] = f1;
        c.firm[2] = f2;
        return c;
    endfunction

    function automatic void add_row(int sel, logic [2:0] mask, logic [31:0] d0,
                                    logic [31:0] d1, logic [31:0] d2, bit typed,
                                    logic pv, logic [1:0] pt, logic [2:0] dm);
        dir_row_t r;
        r.cfg_sel = sel;
        r.mask = mask;
        r.dl[0] = d0;
        r.dl[1] = d1;
        r.dl[2] = d2;
        r.typed = typed;
        r.want.pick_valid = pv;
        r.want.picked_task = pt;
        r.want.dropped_mask = dm;
        dir_rows.push_back(r);
    endfunction

    function automatic logic [31:0] rand_deadline();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1: return 32'($urandom_range(0, 3));
            2: return 32'd0;
            3: return 32'hFFFF_FFFF;
            4: return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] rand_period();
        int r;
        r = $urandom_range(0, 3);
        case (r)
            0: return 16'($urandom_range(0, 3));
            1: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Setup cycle at one falling edge, access at the next; leaves psel high
    task automatic apb_write(int idx, logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx * 4);
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_config(t_cfg c);
        apb_write(REG_MODE, DATA_W'(c.mode));
        for (int t = 0; t < TASK_COUNT; t++) apb_write(REG_PERIOD_BASE + t, DATA_W'(c.period[t]));
        for (int t = 0; t < TASK_COUNT; t++) apb_write(REG_FIRM_BASE + t, DATA_W'(c.firm[t]));
        psel <= 1'b0;
        penable <= 1'b0;
        sched_cfg = c;
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (picks_due.size() != 0) @(negedge i_clk);
    endtask

    // Called and returns at a falling edge; leaves valid high after the item
    task automatic send_request(logic [2:0] mask, t_dl_arr dl, bit typed, pick_t fixed);
        pick_t got;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.ready_mask <= mask;
        req_if.deadline_task0 <= dl[0];
        req_if.deadline_task1 <= dl[1];
        req_if.deadline_task2 <= dl[2];
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        got = predict_pick(mask, dl);
        picks_due.push_back(typed ? fixed : got);
        @(negedge i_clk);
    endtask

    task automatic check_field(string name, logic [2:0] exp_val, logic [2:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    always @(negedge i_clk) begin
        res_if.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (picks_due.size() == 0) begin
                $display("%0t: unexpected item: pick_valid %0d picked_task %0d dropped_mask %0d",
                         $time, res_if.pick_valid, res_if.picked_task, res_if.dropped_mask);
                mismatch_count++;
            end else begin
                want = picks_due.pop_front();
                check_field("pick_valid", 3'(want.pick_valid), 3'(res_if.pick_valid));
                check_field("picked_task", 3'(want.picked_task), 3'(res_if.picked_task));
                check_field("dropped_mask", want.dropped_mask, res_if.dropped_mask);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int         cur_sel;
        t_cfg       cfg;
        logic [2:0] mask;
        t_dl_arr    dl;
        int         k;

        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_if.valid = 1'b0;
        req_if.ready_mask = '0;
        req_if.deadline_task0 = '0;
        req_if.deadline_task1 = '0;
        req_if.deadline_task2 = '0;
        res_if.ready = 1'b0;

        dir_cfgs[0] = '0;   // state after reset
        dir_cfgs[1] = make_cfg(MODE_RMS, 16'hFFFF, 16'h0000, 16'h1234, 8'h00, 8'h00, 8'h00);
        dir_cfgs[2] = make_cfg(MODE_EDF, 16'hFFFF, 16'h0000, 16'h1234, 8'h00, 8'h00, 8'h00);
        dir_cfgs[3] = make_cfg(MODE_SPARE, 16'hFFFF, 16'h0000, 16'h1234, 8'h00, 8'h00, 8'h00);
        // k=3 m=1, k above max, no window
        dir_cfgs[4] = make_cfg(MODE_FIRM, 16'hFFFF, 16'h0000, 16'h1234, 8'h31, 8'hF2, 8'h00);
        // window shrinks under the position, m=0, both fields at max
        dir_cfgs[5] = make_cfg(MODE_FIRM, 16'h0001, 16'h0002, 16'h0003, 8'h11, 8'h80, 8'hFF);

        add_row(0, 3'b000, 32'd0, 32'd0, 32'd0, 1, 1'b0, 2'd0, 3'b000);
        add_row(0, 3'b111, 32'd5, 32'd6, 32'd7, 1, 1'b1, 2'd0, 3'b000);
        add_row(0, 3'b100, 32'd5, 32'd6, 32'd7, 1, 1'b1, 2'd2, 3'b000);
        add_row(1, 3'b111, 32'd0, 32'hFFFF_FFFF, 32'd0, 1, 1'b1, 2'd1, 3'b000);
        add_row(1, 3'b101, 32'd0, 32'd0, 32'hFFFF_FFFF, 1, 1'b1, 2'd2, 3'b000);
        add_row(1, 3'b001, 32'd9, 32'd0, 32'd0, 1, 1'b1, 2'd0, 3'b000);
        add_row(1, 3'b000, 32'd9, 32'd0, 32'd0, 1, 1'b0, 2'd0, 3'b000);
        add_row(2, 3'b111, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1, 2'd0, 3'b000);
        add_row(2, 3'b111, 32'hFFFF_FFFF, 32'h8000_0000, 32'd0, 1, 1'b1, 2'd2, 3'b000);
        add_row(2, 3'b011, 32'd5, 32'd4, 32'd0, 1, 1'b1, 2'd1, 3'b000);
        add_row(2, 3'b110, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1, 1'b1, 2'd2, 3'b000);
        add_row(3, 3'b111, 32'd9, 32'd3, 32'd3, 1, 1'b1, 2'd1, 3'b000);
        add_row(3, 3'b000, 32'd9, 32'd3, 32'd3, 1, 1'b0, 2'd0, 3'b000);
        add_row(4, 3'b111, 32'd10, 32'd20, 32'd30, 0, 1'b0, 2'd0, 3'b000);
        add_row(4, 3'b111, 32'd30, 32'd20, 32'd10, 0, 1'b0, 2'd0, 3'b000);
        add_row(4, 3'b111, 32'd1, 32'd1, 32'd1, 0, 1'b0, 2'd0, 3'b000);
        add_row(4, 3'b011, 32'd0, 32'd0, 32'd0, 0, 1'b0, 2'd0, 3'b000);
        add_row(4, 3'b010, 32'd7, 32'd7, 32'd7, 0, 1'b0, 2'd0, 3'b000);
        add_row(4, 3'b111, 32'hFFFF_FFFF, 32'd0, 32'd5, 0, 1'b0, 2'd0, 3'b000);
        add_row(5, 3'b111, 32'd3, 32'd2, 32'd1, 0, 1'b0, 2'd0, 3'b000);
        add_row(5, 3'b001, 32'd3, 32'd2, 32'd1, 0, 1'b0, 2'd0, 3'b000);
        add_row(5, 3'b111, 32'd1, 32'd2, 32'd3, 0, 1'b0, 2'd0, 3'b000);
        add_row(5, 3'b101, 32'd8, 32'd2, 32'd8, 0, 1'b0, 2'd0, 3'b000);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        cur_sel = 0;
        foreach (dir_rows[r]) begin
            if (dir_rows[r].cfg_sel != cur_sel) begin
                wait_drained();
                load_config(dir_cfgs[dir_rows[r].cfg_sel]);
                cur_sel = dir_rows[r].cfg_sel;
            end
            send_request(dir_rows[r].mask, dir_rows[r].dl, dir_rows[r].typed, dir_rows[r].want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == PHASES - 1) begin
                cfg = make_cfg(MODE_FIRM, 16'hFFFF, 16'h0000, 16'hFFFF, 8'hFF, 8'h88, 8'h81);
            end else begin
                case (ph < 4 ? ph : $urandom_range(0, 9))
                    0, 4, 5: cfg.mode = MODE_RMS;
                    1, 6, 7: cfg.mode = MODE_EDF;
                    3, 8:    cfg.mode = MODE_SPARE;
                    default: cfg.mode = MODE_FIRM;
                endcase
                if (ph >= 4 && $urandom_range(0, 1) != 0) cfg.mode = MODE_FIRM;
                for (int t = 0; t < TASK_COUNT; t++) begin
                    cfg.period[t] = rand_period();
                    k = $urandom_range(0, 15);
                    cfg.firm[t][FIRM_W-1:FIELD_W] = 4'(k);
                    // mostly m within the window so drops keep happening
                    if ($urandom_range(0, 3) == 0)
                        cfg.firm[t][FIELD_W-1:0] = 4'($urandom_range(0, 15));
                    else
                        cfg.firm[t][FIELD_W-1:0] = 4'($urandom_range(0, k > WINDOW_MAX ?
                                                                       WINDOW_MAX : k));
                end
            end
            wait_drained();
            load_config(cfg);
            no_idle = (ph == 4);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 6 && n == ITEMS_PER_PHASE / 2) wait_drained();
                mask = 3'($urandom_range(0, 7));
                for (int t = 0; t < TASK_COUNT; t++) dl[t] = rand_deadline();
                send_request(mask, dl, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
